@@ src/nearest_point_search_assert.svh @@
// Assertion shorthands used by the checker file of the nearest-point search block.
`ifndef NEAREST_POINT_SEARCH_ASSERT_SVH
`define NEAREST_POINT_SEARCH_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define NPS_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define NPS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define NPS_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/nps_pkg.sv @@
package nps_pkg;

  localparam int CoordW = 30;
  localparam int DiffW = CoordW + 1;
  localparam int MagW = CoordW;
  localparam int SqW = 2 * MagW;
  localparam int PairW = SqW + 1;
  localparam int DistW = SqW + 2;
  localparam int OutIdxW = 20;
  localparam int IndexBitsDefault = 20;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CFG_QUERY_X = 2'd0,
    CFG_QUERY_Y = 2'd1,
    CFG_QUERY_Z = 2'd2
  } cfg_reg_t;

  localparam int CfgIdxW = $bits(cfg_reg_t);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // One finished distance handed from the front to the back.
  typedef struct packed {
    logic [DistW-1:0] dist_sq;
    logic             last;
  } entry_t;

  // Queue status seen by its two sides.
  typedef struct packed {
    logic can_push;
    logic not_empty;
  } queue_stat_t;

endpackage

@@ src/nps_point_if.sv @@
interface nps_point_if;
  logic                 valid;
  logic                 ready;
  nps_pkg::coord_t      point_x;
  nps_pkg::coord_t      point_y;
  nps_pkg::coord_t      point_z;
  logic                 last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

@@ src/nps_result_if.sv @@
interface nps_result_if;
  logic                          valid;
  logic                          ready;
  logic [nps_pkg::OutIdxW-1:0]   nearest_index;
  logic [nps_pkg::DistW-1:0]     best_distance_sq;

  modport source (output valid, nearest_index, best_distance_sq, input ready);
  modport sink (input valid, nearest_index, best_distance_sq, output ready);
endinterface

@@ src/nps_front.sv @@
module nps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nps_pkg::point_t      point,
  input  logic                 last_point,
  input  nps_pkg::point_t      query,
  input  nps_pkg::queue_stat_t q_stat,
  output logic                 push,
  output nps_pkg::entry_t      push_entry
);

  // Absolute difference of two coordinates; always fits the coordinate width.
  function automatic logic [nps_pkg::MagW-1:0] abs_diff(input nps_pkg::coord_t a,
                                                        input nps_pkg::coord_t b);
    logic signed [nps_pkg::DiffW-1:0] d;
    d = nps_pkg::DiffW'(a) - nps_pkg::DiffW'(b);
    return d[nps_pkg::DiffW-1] ? nps_pkg::MagW'(-d) : nps_pkg::MagW'(d);
  endfunction

  logic                        v1_r, v2_r, v3_r, v4_r;
  logic                        l1_r, l2_r, l3_r, l4_r;
  logic [nps_pkg::MagW-1:0]    mx_r, my_r, mz_r;
  logic [nps_pkg::SqW-1:0]     sx_r, sy_r, sz_r, sz3_r;
  logic [nps_pkg::PairW-1:0]   sxy_r;
  logic [nps_pkg::DistW-1:0]   dist_r;
  logic                        en;

  // The whole pipeline moves together; it holds only when its tail cannot drain.
  assign en       = !v4_r || q_stat.can_push;
  assign in_ready = en;
  assign push     = v4_r && q_stat.can_push;
  assign push_entry = '{dist_sq: dist_r, last: l4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= abs_diff(point.x, query.x);
      my_r   <= abs_diff(point.y, query.y);
      mz_r   <= abs_diff(point.z, query.z);
      l1_r   <= last_point;
      sx_r   <= nps_pkg::SqW'(mx_r) * nps_pkg::SqW'(mx_r);
      sy_r   <= nps_pkg::SqW'(my_r) * nps_pkg::SqW'(my_r);
      sz_r   <= nps_pkg::SqW'(mz_r) * nps_pkg::SqW'(mz_r);
      l2_r   <= l1_r;
      sxy_r  <= nps_pkg::PairW'(sx_r) + nps_pkg::PairW'(sy_r);
      sz3_r  <= sz_r;
      l3_r   <= l2_r;
      dist_r <= nps_pkg::DistW'(sxy_r) + nps_pkg::DistW'(sz3_r);
      l4_r   <= l3_r;
    end
  end

endmodule

@@ src/nps_queue.sv @@
module nps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nps_pkg::entry_t      push_entry,
  input  logic                 pop,
  output nps_pkg::entry_t      head,
  output nps_pkg::queue_stat_t stat
);

  nps_pkg::entry_t                 mem_r [nps_pkg::QueueDepth];
  logic [nps_pkg::QueuePtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [nps_pkg::QueuePtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [nps_pkg::QueueCntW-1:0]   cnt_r, cnt_nxt;
  logic                            do_pop;

  assign do_pop         = pop && (cnt_r != '0);
  assign stat.not_empty = (cnt_r != '0);
  assign stat.can_push  = (cnt_r != nps_pkg::QueueCntW'(nps_pkg::QueueDepth)) || do_pop;
  assign head           = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == nps_pkg::QueuePtrW'(nps_pkg::QueueDepth - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == nps_pkg::QueuePtrW'(nps_pkg::QueueDepth - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/nps_back.sv @@
module nps_back #(
  parameter int INDEX_BITS = nps_pkg::IndexBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nps_pkg::queue_stat_t        q_stat,
  input  nps_pkg::entry_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nps_pkg::OutIdxW-1:0] out_index,
  output logic [nps_pkg::DistW-1:0]   out_dist
);

  logic [INDEX_BITS-1:0]          cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0]          best_idx_r, best_idx_nxt;
  logic [nps_pkg::DistW-1:0]      best_dist_r, best_dist_nxt;
  logic                           have_best_r, have_best_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nps_pkg::OutIdxW-1:0]    out_idx_r;
  logic [nps_pkg::DistW-1:0]      out_dist_r;
  logic                           better;
  logic [INDEX_BITS-1:0]          cand_idx;
  logic [nps_pkg::DistW-1:0]      cand_dist;
  logic [nps_pkg::OutIdxW-1:0]    cand_idx_out;

  // A last beat needs the result register free; other beats never wait.
  assign pop = q_stat.not_empty && (!head.last || !out_valid_r || out_ready);

  // Strictly smaller wins, so ties keep the earlier point.
  assign better    = !have_best_r || (head.dist_sq < best_dist_r);
  assign cand_idx  = better ? cnt_r : best_idx_r;
  assign cand_dist = better ? head.dist_sq : best_dist_r;

  if (INDEX_BITS >= nps_pkg::OutIdxW) begin : g_idx_trunc
    assign cand_idx_out = cand_idx[nps_pkg::OutIdxW-1:0];
  end else begin : g_idx_ext
    assign cand_idx_out = {{(nps_pkg::OutIdxW - INDEX_BITS){1'b0}}, cand_idx};
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    have_best_nxt = have_best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (head.last) begin
        cnt_nxt       = '0;
        have_best_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        cnt_nxt       = cnt_r + 1'b1;
        best_idx_nxt  = cand_idx;
        best_dist_nxt = cand_dist;
        have_best_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    if (pop && head.last) begin
      out_idx_r  <= cand_idx_out;
      out_dist_r <= cand_dist;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_idx_r;
  assign out_dist  = out_dist_r;

endmodule

@@ src/nearest_point_search.sv @@
// Nearest-point search over a streamed point cloud. Load the query point
// through the configuration port (index 0, 1 and 2 for x, y and z, 30-bit
// signed millimeters) while the block is idle, then stream cloud points on
// in_point, one beat per point, with last_point set on the final one. For
// every point the block forms the exact 62-bit squared Euclidean distance to
// the query and keeps the smallest, earlier points winning ties. After the
// last beat it presents one result beat with the stream position of the
// closest point and its squared distance, then starts over for the next
// cloud. Points are taken at one per clock cycle for as long as the result
// side keeps up; a finished result waiting on out_result does not hold up
// the points behind it until the four-entry queue between the distance
// pipeline and the minimum tracker is full. The distance pipeline registers
// the difference, the square and two adds in turn; the queue then takes the
// distance, and the result register loads from the queue head when free.
// Stream positions count modulo 2^INDEX_BITS and are reported in 20 bits.
module nearest_point_search #(
  parameter int INDEX_BITS = nps_pkg::IndexBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nps_point_if.sink                    in_point,
  nps_result_if.source                 out_result,
  input  logic                         cfg_we,
  input  logic [nps_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [nps_pkg::CoordW-1:0]   cfg_data
);

  nps_pkg::coord_t       query_x_r, query_y_r, query_z_r;
  nps_pkg::point_t       query;
  nps_pkg::point_t       point;
  nps_pkg::queue_stat_t  q_stat;
  nps_pkg::entry_t       push_entry;
  nps_pkg::entry_t       head;
  logic                  push;
  logic                  pop;

  // Query registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
      query_z_r <= '0;
    end else if (cfg_we) begin
      unique case (nps_pkg::cfg_reg_t'(cfg_idx))
        nps_pkg::CFG_QUERY_X: query_x_r <= nps_pkg::coord_t'(cfg_data);
        nps_pkg::CFG_QUERY_Y: query_y_r <= nps_pkg::coord_t'(cfg_data);
        nps_pkg::CFG_QUERY_Z: query_z_r <= nps_pkg::coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign query = '{x: query_x_r, y: query_y_r, z: query_z_r};
  assign point = '{x: in_point.point_x, y: in_point.point_y, z: in_point.point_z};

  // Front: distance pipeline, fed straight from the input channel.
  nps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_point.valid),
    .in_ready   (in_point.ready),
    .point      (point),
    .last_point (in_point.last_point),
    .query      (query),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Short queue that lets the front keep running while a result waits.
  nps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // Back: running minimum, stream position and the result register.
  nps_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_result.valid),
    .out_ready (out_result.ready),
    .out_index (out_result.nearest_index),
    .out_dist  (out_result.best_distance_sq)
  );

endmodule

@@ src/nps_checker.sv @@
`include "nearest_point_search_assert.svh"

module nps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [nps_pkg::OutIdxW-1:0] out_index,
  input logic [nps_pkg::DistW-1:0]   out_dist
);

  // Reset leaves no result pending.
  `NPS_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid, "result pending after reset")

  // Input back-pressure only comes from a result that is waiting to be taken.
  `NPS_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")

  // A waiting result beat stays and keeps its payload.
  `NPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_dist), "result beat changed while stalled")

endmodule

bind nearest_point_search nps_checker u_nps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_point.ready),
  .out_valid (out_result.valid),
  .out_ready (out_result.ready),
  .out_index (out_result.nearest_index),
  .out_dist  (out_result.best_distance_sq)
);
